// ===== hw/rtl/tvfp_pkg.sv =====
`default_nettype none

package tvfp_pkg;

   localparam int unsigned TAG_W = 27;
   localparam int unsigned BYTE_W = 8;

   localparam logic [BYTE_W-1:0] SOH_BYTE = 8'h01;
   localparam logic [BYTE_W-1:0] EQ_BYTE = 8'h3D;
   localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
   localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

   localparam logic [TAG_W-1:0] TAG_MAX_VAL = {TAG_W{1'b1}};

   // one result transaction
   typedef struct packed {
      logic [BYTE_W-1:0] value_byte;
      logic [TAG_W-1:0]  field_tag;
      logic              field_end;
      logic              field_ok;
      logic              err_tag_too_long;
      logic              err_bad_tag;
      logic              err_no_equals;
      logic              err_no_value;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tvfp_parse.sv =====
`default_nettype none

module tvfp_parse import tvfp_pkg::*; #(
   parameter int unsigned MAX_TAG_DIGITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [BYTE_W-1:0] in_byte,
   output logic                   res_valid,
   output rsp_type                res
);

   localparam int unsigned CNT_W = $clog2(MAX_TAG_DIGITS + 1);
   localparam int unsigned MUL_W = TAG_W + 4;

   localparam logic [1:0] PH_TAG       = 2'd0;
   localparam logic [1:0] PH_VAL_EMPTY = 2'd1;
   localparam logic [1:0] PH_VAL_FULL  = 2'd2;
   localparam logic [1:0] PH_SKIP      = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TAG_W-1:0] accum_ff, accum_in;
   logic             digits_open_ff, digits_open_in;
   logic             saw_digit_ff, saw_digit_in;
   logic             too_long_ff, too_long_in;

   logic             is_soh, is_eq, is_digit;
   logic [MUL_W-1:0] acc_wide;
   logic [MUL_W-1:0] acc_next;

   assign is_soh   = (in_byte == SOH_BYTE);
   assign is_eq    = (in_byte == EQ_BYTE);
   assign is_digit = (in_byte inside {[DIGIT_LO:DIGIT_HI]});

   // accum*10 + digit, shift-add
   assign acc_wide = {4'b0, accum_ff};
   assign acc_next = (acc_wide << 3) + (acc_wide << 1)
                   + MUL_W'(in_byte - DIGIT_LO);

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      accum_in       = accum_ff;
      digits_open_in = digits_open_ff;
      saw_digit_in   = saw_digit_ff;
      too_long_in    = too_long_ff;
      res_valid      = 1'b0;
      res            = '0;
      res.field_tag  = accum_ff;

      if (is_soh) begin
         res_valid            = 1'b1;
         res.field_end        = 1'b1;
         res.err_tag_too_long = too_long_ff;
         res.err_bad_tag      = !saw_digit_ff;
         res.err_no_equals    = (phase_ff == PH_TAG) || (phase_ff == PH_SKIP);
         res.err_no_value     = (phase_ff == PH_TAG) || (phase_ff == PH_VAL_EMPTY);
         res.field_ok         = !(res.err_tag_too_long || res.err_bad_tag ||
                                  res.err_no_equals || res.err_no_value);
         phase_in       = PH_TAG;
         count_in       = '0;
         accum_in       = '0;
         digits_open_in = 1'b1;
         saw_digit_in   = 1'b0;
         too_long_in    = 1'b0;
      end else begin
         case (phase_ff)
            PH_TAG: begin
               if (is_eq) begin
                  phase_in = PH_VAL_EMPTY;
               end else if (count_ff >= CNT_W'(MAX_TAG_DIGITS)) begin
                  too_long_in = 1'b1;
                  phase_in    = PH_SKIP;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (digits_open_ff) begin
                     if (is_digit) begin
                        accum_in = (acc_next > MUL_W'(TAG_MAX_VAL)) ?
                                   TAG_MAX_VAL : acc_next[TAG_W-1:0];
                        saw_digit_in = 1'b1;
                     end else begin
                        digits_open_in = 1'b0;
                     end
                  end
               end
            end
            PH_VAL_EMPTY, PH_VAL_FULL: begin
               phase_in = PH_VAL_FULL;
               if (saw_digit_ff) begin
                  res_valid      = 1'b1;
                  res.value_byte = in_byte;
               end
            end
            default: begin
               // skipping to SOH
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TAG;
         count_ff       <= '0;
         accum_ff       <= '0;
         digits_open_ff <= 1'b1;
         saw_digit_ff   <= 1'b0;
         too_long_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         accum_ff       <= accum_in;
         digits_open_ff <= digits_open_in;
         saw_digit_ff   <= saw_digit_in;
         too_long_ff    <= too_long_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tvfp_out.sv =====
`default_nettype none

module tvfp_out import tvfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_data,
   input  wire logic    rsp_stall,
   output logic         out_free,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds while stalled; only loads when the slot is free
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tag_value_field_parser.sv =====
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_in_byte
// rsp      out        rsp_valid/rsp_stall   rsp_value_byte, rsp_field_tag, flags
//
// One byte per cycle unless held by a stalled rsp: a byte is registered on
// acceptance, parsed from the input register, and any result is loaded into
// the output register, which drives rsp_valid.
// Synchronous active-high reset clears the parser state and both valid flags.
// A stalled rsp holds; the input register then waits only if the byte it
// holds produces a result, so req_stall follows rsp_stall in the same cycle.

module tag_value_field_parser import tvfp_pkg::*; #(
   parameter int unsigned MAX_TAG_DIGITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_in_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_value_byte,
   output logic [TAG_W-1:0]       rsp_field_tag,
   output logic                   rsp_field_end,
   output logic                   rsp_field_ok,
   output logic                   rsp_err_tag_too_long,
   output logic                   rsp_err_bad_tag,
   output logic                   rsp_err_no_equals,
   output logic                   rsp_err_no_value
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   logic    accept;
   logic    advance;
   logic    res_valid;
   rsp_type res;
   logic    out_free;
   rsp_type rsp_data;

   // a byte that yields no transaction never waits on the output
   assign advance   = in_valid_ff && (!res_valid || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // field state and per-byte decode
   tvfp_parse #(
      .MAX_TAG_DIGITS (MAX_TAG_DIGITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   tvfp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .load_data (res),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_value_byte       = rsp_data.value_byte;
   assign rsp_field_tag        = rsp_data.field_tag;
   assign rsp_field_end        = rsp_data.field_end;
   assign rsp_field_ok         = rsp_data.field_ok;
   assign rsp_err_tag_too_long = rsp_data.err_tag_too_long;
   assign rsp_err_bad_tag      = rsp_data.err_bad_tag;
   assign rsp_err_no_equals    = rsp_data.err_no_equals;
   assign rsp_err_no_value     = rsp_data.err_no_value;

endmodule

`default_nettype wire
